### design/hsvpwm_pkg.sv
`default_nettype none
package hsvpwm_pkg;

	// Queue between the converter and the PWM write sequencer
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration register indexes
	localparam logic [1:0] CFG_RED   = 2'd0;
	localparam logic [1:0] CFG_GREEN = 2'd1;
	localparam logic [1:0] CFG_BLUE  = 2'd2;

	// Command codes
	localparam logic CMD_RGB = 1'b0;
	localparam logic CMD_HSV = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [8:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
	} in_t;

	typedef struct packed {
		logic [3:0]  channel;
		logic [11:0] duty;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [3:0] red_channel;
		logic [3:0] green_channel;
		logic [3:0] blue_channel;
	} cfg_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

endpackage
`default_nettype wire

### design/hsvpwm_front.sv
`default_nettype none
module hsvpwm_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire hsvpwm_pkg::in_t   req,
	output logic                   push,
	output hsvpwm_pkg::rgb_t       push_data
);

	// Sector codes, grey for hue of 360 and above
	localparam logic [2:0] SEC_0    = 3'd0;
	localparam logic [2:0] SEC_1    = 3'd1;
	localparam logic [2:0] SEC_2    = 3'd2;
	localparam logic [2:0] SEC_3    = 3'd3;
	localparam logic [2:0] SEC_4    = 3'd4;
	localparam logic [2:0] SEC_5    = 3'd5;
	localparam logic [2:0] SEC_GREY = 3'd6;

	// Stage 0: sector, position inside the double sector, v*s
	logic [2:0]  sec;
	logic [8:0]  base;
	logic [6:0]  t;
	logic [5:0]  span;
	logic [5:0]  w;
	logic [15:0] prod;

	always_comb begin
		if (req.hue < 9'd60)       sec = SEC_0;
		else if (req.hue < 9'd120) sec = SEC_1;
		else if (req.hue < 9'd180) sec = SEC_2;
		else if (req.hue < 9'd240) sec = SEC_3;
		else if (req.hue < 9'd300) sec = SEC_4;
		else if (req.hue < 9'd360) sec = SEC_5;
		else                       sec = SEC_GREY;
		case (sec)
			SEC_0, SEC_1: base = 9'd0;
			SEC_2, SEC_3: base = 9'd120;
			SEC_4, SEC_5: base = 9'd240;
			default:      base = req.hue;
		endcase
		t    = 7'(req.hue - base);
		span = (t >= 7'd60) ? 6'(t - 7'd60) : 6'(7'd60 - t);
		w    = 6'd60 - span;
		prod = 16'(req.brightness) * 16'(req.saturation);
	end

	logic        vld_s1;
	logic        cmd_s1;
	hsvpwm_pkg::rgb_t rgb_s1;
	logic [2:0]  sec_s1;
	logic [5:0]  w_s1;
	logic [15:0] prod_s1;
	logic [7:0]  v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= req.cmd;
			rgb_s1  <= '{r: req.red, g: req.green, b: req.blue};
			sec_s1  <= sec;
			w_s1    <= w;
			prod_s1 <= prod;
			v_s1    <= req.brightness;
		end
	end

	// Stage 1: chroma = v*s/255 (exact for products of two 8-bit values), then C*w
	logic [15:0] csum;
	logic [7:0]  chroma;
	logic [13:0] cw;

	always_comb begin
		csum   = prod_s1 + 16'(prod_s1[15:8]) + 16'd1;
		chroma = csum[15:8];
		cw     = 14'(chroma) * 14'(w_s1);
	end

	logic        vld_s2;
	logic        cmd_s2;
	hsvpwm_pkg::rgb_t rgb_s2;
	logic [2:0]  sec_s2;
	logic [7:0]  c_s2;
	logic [7:0]  m_s2;
	logic [13:0] cw_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			cmd_s2 <= cmd_s1;
			rgb_s2 <= rgb_s1;
			sec_s2 <= sec_s1;
			c_s2   <= chroma;
			m_s2   <= v_s1 - chroma;
			cw_s2  <= cw;
		end
	end

	// Stage 2: X = C*w/60 as ((y/4)+1)*4369 >> 16
	logic [11:0] quarter;
	logic [24:0] xprod;

	always_comb begin
		quarter = cw_s2[13:2] + 12'd1;
		xprod   = 25'(quarter) * 25'd4369;
	end

	logic        vld_s3;
	logic        cmd_s3;
	hsvpwm_pkg::rgb_t rgb_s3;
	logic [2:0]  sec_s3;
	logic [7:0]  c_s3;
	logic [7:0]  m_s3;
	logic [7:0]  x_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			cmd_s3 <= cmd_s2;
			rgb_s3 <= rgb_s2;
			sec_s3 <= sec_s2;
			c_s3   <= c_s2;
			m_s3   <= m_s2;
			x_s3   <= xprod[23:16];
		end
	end

	// Stage 3: place C and X by sector, add the offset, or pass direct bytes
	logic [7:0] rr, gg, bb;

	always_comb begin
		rr = 8'd0;
		gg = 8'd0;
		bb = 8'd0;
		case (sec_s3)
			SEC_0: begin rr = c_s3; gg = x_s3; end
			SEC_1: begin rr = x_s3; gg = c_s3; end
			SEC_2: begin gg = c_s3; bb = x_s3; end
			SEC_3: begin gg = x_s3; bb = c_s3; end
			SEC_4: begin rr = x_s3; bb = c_s3; end
			SEC_5: begin rr = c_s3; bb = x_s3; end
			default: ;
		endcase
		push = vld_s3;
		if (cmd_s3 == hsvpwm_pkg::CMD_HSV) begin
			push_data = '{r: rr + m_s3, g: gg + m_s3, b: bb + m_s3};
		end else begin
			push_data = rgb_s3;
		end
	end

endmodule
`default_nettype wire

### design/hsvpwm_fifo.sv
`default_nettype none
module hsvpwm_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire hsvpwm_pkg::rgb_t push_data,
	input  wire logic             pop,
	output hsvpwm_pkg::rgb_t      head,
	output logic                  empty
);

	hsvpwm_pkg::rgb_t mem_q [hsvpwm_pkg::QDEPTH];
	logic [hsvpwm_pkg::QPTR_W-1:0] wptr_q, rptr_q;
	logic [hsvpwm_pkg::QCNT_W-1:0] cnt_q;

	// Pointers and fill count; the top level's credit counter keeps it from overflowing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_data;
	end

	assign head  = mem_q[rptr_q];
	assign empty = (cnt_q == '0);

endmodule
`default_nettype wire

### design/hsvpwm_back.sv
`default_nettype none
module hsvpwm_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hsvpwm_pkg::cfg_t cfg,
	input  wire hsvpwm_pkg::rgb_t head,
	input  wire logic             empty,
	output logic                  pop,
	output logic                  strobe,
	output hsvpwm_pkg::out_t      result
);

	localparam logic [1:0] PH_RED   = 2'd0;
	localparam logic [1:0] PH_GREEN = 2'd1;
	localparam logic [1:0] PH_BLUE  = 2'd2;

	logic [1:0]  phase_q;
	logic [7:0]  byte_sel;
	logic [3:0]  chan_sel;
	logic [15:0] frac;
	logic [11:0] duty;
	logic        strobe_q;
	hsvpwm_pkg::out_t out_q;

	// Pick the color of this phase; duty = 16*b + b/17 == b*4095/255
	always_comb begin
		case (phase_q)
			PH_GREEN: begin byte_sel = head.g; chan_sel = cfg.green_channel; end
			PH_BLUE:  begin byte_sel = head.b; chan_sel = cfg.blue_channel;  end
			default:  begin byte_sel = head.r; chan_sel = cfg.red_channel;   end
		endcase
		frac = 16'(byte_sel) * 16'd241;
		duty = {byte_sel, 4'd0} + 12'(frac[15:12]);
		pop  = !empty && (phase_q == PH_BLUE);
	end

	// One write per cycle while an entry waits; retire it after blue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_RED;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= !empty;
			if (!empty) begin
				phase_q <= (phase_q == PH_BLUE) ? PH_RED : phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!empty) begin
			out_q <= '{channel: chan_sel, duty: duty, last: (phase_q == PH_BLUE)};
		end
	end

	assign strobe = strobe_q;
	assign result = out_q;

endmodule
`default_nettype wire

### design/hsv_to_rgb_pwm_driver.sv
// Channel   Dir  Handshake            Payload
// request   in   start / busy         req    (hsvpwm_pkg::in_t)
// result    out  strobe, no backpress result (hsvpwm_pkg::out_t)
// config    in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each request yields three writes (red, green, blue) on consecutive cycles.
// Up to four requests are taken back to back; the sustained rate is set by
// the write sequencer emitting one write a cycle, three writes per request.
// The red write passes stage registers s1, s2, s3, the queue and the output register.
// arst_n clears pipeline valids, queue, sequencer and channel registers (0).
// busy rises when four requests are held in the converter and the queue.
`default_nettype none
module hsv_to_rgb_pwm_driver (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire hsvpwm_pkg::in_t   req,
	output logic                   strobe,
	output hsvpwm_pkg::out_t       result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [3:0]        cfg_data
);

	logic accept;
	logic push, pop, empty;
	hsvpwm_pkg::rgb_t push_data, head;
	hsvpwm_pkg::cfg_t cfg_q;
	logic [hsvpwm_pkg::QCNT_W-1:0] credit_q;

	assign cfg_ready = 1'b1;
	assign busy      = (credit_q == hsvpwm_pkg::QCNT_W'(hsvpwm_pkg::QDEPTH));
	assign accept    = start && !busy;

	// Channel registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hsvpwm_pkg::CFG_RED:   cfg_q.red_channel   <= cfg_data;
				hsvpwm_pkg::CFG_GREEN: cfg_q.green_channel <= cfg_data;
				hsvpwm_pkg::CFG_BLUE:  cfg_q.blue_channel  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Requests in the converter or queue; bounds queue occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({accept, pop})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	hsvpwm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req       (req),
		.push      (push),
		.push_data (push_data)
	);

	hsvpwm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	hsvpwm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

endmodule
`default_nettype wire

### design/hsvpwm_chk.sv
`default_nettype none
module hsvpwm_chk (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             strobe,
	input wire hsvpwm_pkg::out_t result
);

	// A run opens with a non-last write
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !$past(strobe) |-> !result.last)
		else $error("write run starts with last set");

	// A non-last write is always followed by another write
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("write run broken before blue");

	// Two non-last writes in a row are followed by the last one
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last && $past(strobe) && !$past(result.last)
		|=> strobe && result.last)
		else $error("blue write missing after green");

	// The last write follows a non-last write
	a_last_prev: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> $past(strobe) && !$past(result.last))
		else $error("last write without preceding green");

endmodule

bind hsv_to_rgb_pwm_driver hsvpwm_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.strobe (strobe),
	.result (result)
);
`default_nettype wire

### tb/tb_hsv_to_rgb_pwm_driver.sv
`timescale 1ns / 1ps
module tb_hsv_to_rgb_pwm_driver;

	localparam int          LIMIT_CYCLES  = 200000;
	localparam int          DRAIN_CYCLES  = 12;
	localparam int          RANDOM_PHASES = 6;
	localparam int          PHASE_ITEMS   = 74;
	localparam int          MAX_PRINTS    = 40;
	// index 3 decodes to no register
	localparam logic [1:0]  CFG_UNUSED    = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	hsvpwm_pkg::in_t   req;
	logic              strobe;
	hsvpwm_pkg::out_t  result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [3:0]        cfg_data;

	// channel map as the block should hold it
	hsvpwm_pkg::cfg_t  chan_map;
	hsvpwm_pkg::out_t  pending_writes[$];
	int                mismatches  = 0;
	int                cycle_count = 0;

	hsv_to_rgb_pwm_driver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.strobe    (strobe),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// ---------------- color math ----------------

	function automatic logic [11:0] color_to_duty(input logic [7:0] level);
		int unsigned scaled;
		scaled = int'(level) * 4095 / 255;
		return scaled[11:0];
	endfunction

	// six-sector HSV to RGB, truncating at each step
	function automatic hsvpwm_pkg::rgb_t hsv_to_color(input logic [8:0] h,
			input logic [7:0] s, input logic [7:0] v);
		int unsigned hh, chroma, pos, span, mid, offset;
		int unsigned rr, gg, bb;
		hsvpwm_pkg::rgb_t col;
		hh     = h;
		chroma = int'(v) * int'(s) / 255;
		pos    = hh % 120;
		span   = (pos >= 60) ? pos - 60 : 60 - pos;
		mid    = chroma * (60 - span) / 60;
		offset = int'(v) - chroma;
		rr = 0;
		gg = 0;
		bb = 0;
		case (hh / 60)
			0: begin rr = chroma; gg = mid;    end
			1: begin rr = mid;    gg = chroma; end
			2: begin gg = chroma; bb = mid;    end
			3: begin gg = mid;    bb = chroma; end
			4: begin rr = mid;    bb = chroma; end
			5: begin rr = chroma; bb = mid;    end
			default: ; // grey
		endcase
		col.r = 8'(rr + offset);
		col.g = 8'(gg + offset);
		col.b = 8'(bb + offset);
		return col;
	endfunction

	// three PWM writes per request: red, green, blue
	task automatic queue_pwm_writes(input hsvpwm_pkg::in_t item);
		hsvpwm_pkg::rgb_t col;
		hsvpwm_pkg::out_t w;
		if (item.cmd == hsvpwm_pkg::CMD_RGB) begin
			col.r = item.red;
			col.g = item.green;
			col.b = item.blue;
		end else begin
			col = hsv_to_color(item.hue, item.saturation, item.brightness);
		end
		w.channel = chan_map.red_channel;
		w.duty    = color_to_duty(col.r);
		w.last    = 1'b0;
		pending_writes.push_back(w);
		w.channel = chan_map.green_channel;
		w.duty    = color_to_duty(col.g);
		pending_writes.push_back(w);
		w.channel = chan_map.blue_channel;
		w.duty    = color_to_duty(col.b);
		w.last    = 1'b1;
		pending_writes.push_back(w);
	endtask

	// ---------------- result checker ----------------

	always @(posedge clk) begin
		hsvpwm_pkg::out_t want;
		if (arst_n && strobe) begin
			if (pending_writes.size() == 0) begin
				report_mismatch($sformatf("unexpected write ch=%0d duty=%0d last=%0b",
					result.channel, result.duty, result.last));
			end else begin
				want = pending_writes.pop_front();
				if (result.channel !== want.channel)
					report_mismatch($sformatf("channel %0d, want %0d",
						result.channel, want.channel));
				if (result.duty !== want.duty)
					report_mismatch($sformatf("duty %0d, want %0d (ch %0d)",
						result.duty, want.duty, want.channel));
				if (result.last !== want.last)
					report_mismatch($sformatf("last %0b, want %0b",
						result.last, want.last));
			end
		end
	end

	// ---------------- drivers ----------------

	// start stays high on return so back-to-back requests need no re-raise
	task automatic send_request(input hsvpwm_pkg::in_t item);
		start <= 1'b1;
		req   <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		queue_pwm_writes(item);
	endtask

	task automatic idle_for(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// wait until every expected write has shown up, plus pipeline slack
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller lowers it
	task automatic write_channel(input logic [1:0] idx, input logic [3:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			hsvpwm_pkg::CFG_RED:   chan_map.red_channel   = val;
			hsvpwm_pkg::CFG_GREEN: chan_map.green_channel = val;
			hsvpwm_pkg::CFG_BLUE:  chan_map.blue_channel  = val;
			default:   ; // ignored by the block
		endcase
	endtask

	task automatic set_channels(input logic [3:0] r, input logic [3:0] g,
			input logic [3:0] b);
		write_channel(hsvpwm_pkg::CFG_RED, r);
		write_channel(hsvpwm_pkg::CFG_GREEN, g);
		write_channel(hsvpwm_pkg::CFG_BLUE, b);
		cfg_valid <= 1'b0;
	endtask

	// ---------------- request builders ----------------

	function automatic hsvpwm_pkg::in_t make_rgb(input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		hsvpwm_pkg::in_t item;
		item            = '0;
		item.cmd        = hsvpwm_pkg::CMD_RGB;
		item.red        = r;
		item.green      = g;
		item.blue       = b;
		item.hue        = 9'($urandom_range(0, 511));
		item.saturation = 8'($urandom);
		item.brightness = 8'($urandom);
		return item;
	endfunction

	function automatic hsvpwm_pkg::in_t make_hsv(input logic [8:0] h,
			input logic [7:0] s, input logic [7:0] v);
		hsvpwm_pkg::in_t item;
		item            = make_rgb(8'($urandom), 8'($urandom), 8'($urandom));
		item.cmd        = hsvpwm_pkg::CMD_HSV;
		item.hue        = h;
		item.saturation = s;
		item.brightness = v;
		return item;
	endfunction

	function automatic logic [7:0] pick_fraction();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic hsvpwm_pkg::in_t make_random_request();
		logic [8:0] h;
		if ($urandom_range(0, 4) < 2)
			return make_rgb(pick_fraction(), pick_fraction(), pick_fraction());
		// mostly real hues, some in the grey range
		h = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(360, 511))
		                                : 9'($urandom_range(0, 359));
		return make_hsv(h, pick_fraction(), pick_fraction());
	endfunction

	// ---------------- tests ----------------

	// register writes, including an unmapped index and the extremes
	task automatic test_channel_registers();
		wait_drained();
		write_channel(CFG_UNUSED, 4'hA);
		set_channels(4'd15, 4'd0, 4'd7);
		send_request(make_rgb(8'd1, 8'd2, 8'd3));
		send_request(make_hsv(9'd45, 8'd200, 8'd180));
		wait_drained();
	endtask

	task automatic test_direct_colors();
		send_request(make_rgb(8'd0, 8'd0, 8'd0));
		send_request(make_rgb(8'd255, 8'd255, 8'd255));
		idle_for(2);
		send_request(make_rgb(8'h55, 8'hAA, 8'h01));
		send_request(make_rgb(8'hAA, 8'h55, 8'h80));
		wait_drained();
	endtask

	// sector edges on both sides, zero saturation, zero brightness
	task automatic test_hsv_sectors();
		int hues[13] = '{0, 30, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359};
		foreach (hues[i]) begin
			send_request(make_hsv(9'(hues[i]), 8'd255, (i % 2) ? 8'd255 : 8'd201));
			if (i % 4 == 3)
				idle_for($urandom_range(1, 4));
		end
		send_request(make_hsv(9'd100, 8'd0, 8'd200));
		send_request(make_hsv(9'd200, 8'd255, 8'd0));
		wait_drained();
	endtask

	// hue at or beyond 360 gives grey at the offset level
	task automatic test_grey_hues();
		send_request(make_hsv(9'd360, 8'd255, 8'd255));
		send_request(make_hsv(9'd400, 8'd128, 8'd77));
		send_request(make_hsv(9'd511, 8'd255, 8'd255));
		wait_drained();
	endtask

	task automatic test_random_traffic();
		bit idle_on;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				1:       set_channels(4'd15, 4'd15, 4'd15);
				2:       set_channels(4'd0, 4'd0, 4'd0);
				default: set_channels(4'($urandom), 4'($urandom), 4'($urandom));
			endcase
			idle_on = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// alternate stretches with and without sender gaps; none at the end
				if (n % 16 == 0)
					idle_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 2) != 0);
				if (idle_on && $urandom_range(0, 2) == 0)
					idle_for($urandom_range(1, 4));
				send_request(make_random_request());
			end
			wait_drained();
		end
	endtask

	// ---------------- sequence ----------------

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= hsvpwm_pkg::CFG_RED;
		cfg_data  <= '0;
		chan_map   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset channel map (all zero) first
		test_direct_colors();
		test_channel_registers();
		test_hsv_sectors();
		test_grey_hues();
		test_random_traffic();

		wait_drained();
		if (pending_writes.size() != 0)
			report_mismatch($sformatf("%0d writes never arrived", pending_writes.size()));
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
design/hsvpwm_pkg.sv
design/hsvpwm_front.sv
design/hsvpwm_fifo.sv
design/hsvpwm_back.sv
design/hsv_to_rgb_pwm_driver.sv
design/hsvpwm_chk.sv
tb/tb_hsv_to_rgb_pwm_driver.sv
